// ----- sv/amsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amsd_pkg
// Shared types and constants for the accelerometer magnitude stillness
// detector: field widths, scaling constants and the state machine encodings.
// ----------------------------------------------------------------------------
package amsd_pkg;

	// field widths
	localparam int AXIS_W = 16;
	localparam int SUM_W  = 32;
	localparam int ROOT_W = 16;
	localparam int MAG_W  = 12;
	localparam int PROD_W = 26;

	// milli-g scaling: mg = (root * 1000) >> 14
	localparam logic [PROD_W-1:0] MG_PER_G  = PROD_W'(1000);
	localparam int                LSB_SHIFT = 14;

	// largest magnitude in milli-g (all axes at full negative scale)
	localparam logic [MAG_W-1:0] MG_MAX = MAG_W'(3464);

	// threshold after reset
	localparam logic [MAG_W-1:0] THRESH_RESET = MAG_W'(50);

	// first trial bit of the square root, highest even bit of the sum
	localparam logic [SUM_W-1:0] ROOT_BIT0 = 32'h4000_0000;

	// index of the last axis in the squaring pass
	localparam logic [1:0] AXIS_LAST = 2'd2;

	// front state machine
	typedef enum logic [2:0] {
		F_IDLE,
		F_SQUARE,
		F_ROOT,
		F_SCALE,
		F_PUSH
	} front_state_t;

	// back state machine
	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DRAIN,
		B_EMIT
	} back_state_t;

	// status of the magnitude queue as seen by its two sides
	typedef struct packed {
		logic full;
		logic empty;
	} mq_status_t;

endpackage : amsd_pkg
`default_nettype wire

// ----- sv/amsd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amsd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module amsd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : amsd_ram
`default_nettype wire

// ----- sv/amsd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amsd_front
// Accepts one sample, squares and sums the three axes on one multiplier,
// takes the floor square root one result bit per cycle, scales to milli-g
// and pushes the magnitude into the queue toward the back end.
// ----------------------------------------------------------------------------
module amsd_front import amsd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [AXIS_W-1:0] accel_x,
	input  wire logic signed [AXIS_W-1:0] accel_y,
	input  wire logic signed [AXIS_W-1:0] accel_z,
	input  wire mq_status_t               mq_stat,
	output logic                          mq_push,
	output logic      [MAG_W-1:0]         mq_data
);

	front_state_t state_q, state_d;

	logic signed [AXIS_W-1:0] ax_q, ay_q, az_q;
	logic [1:0]               axis_cnt_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W-1:0]         sq;
	logic [SUM_W-1:0]         sum_d;
	logic [SUM_W-1:0]         rem_q;
	logic [SUM_W-1:0]         res_q;
	logic [SUM_W-1:0]         bit_q;
	logic [SUM_W-1:0]         trial;
	logic [PROD_W-1:0]        prod;
	logic [MAG_W-1:0]         mg_q;
	logic                     accept;

	assign accept = push && !full;

	// one square per cycle, added to the running sum
	assign sq    = $unsigned(SUM_W'(ax_q) * SUM_W'(ax_q));
	assign sum_d = sum_q + sq;

	// square root trial value
	assign trial = res_q + bit_q;

	// milli-g scaling
	assign prod = PROD_W'(res_q[ROOT_W-1:0]) * MG_PER_G;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:   if (accept) state_d = F_SQUARE;
			F_SQUARE: if (axis_cnt_q == AXIS_LAST) state_d = F_ROOT;
			F_ROOT:   if (bit_q[0]) state_d = F_SCALE;
			F_SCALE:  state_d = F_PUSH;
			F_PUSH:   if (!mq_stat.full) state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		full    = 1'b1;
		mq_push = 1'b0;
		unique case (state_q)
			F_IDLE:  full = 1'b0;
			F_PUSH:  mq_push = !mq_stat.full;
			default: ;
		endcase
	end

	assign mq_data = mg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			axis_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				axis_cnt_q <= '0;
			end else if (state_q == F_SQUARE) begin
				axis_cnt_q <= axis_cnt_q + 2'd1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q  <= accel_x;
			ay_q  <= accel_y;
			az_q  <= accel_z;
			sum_q <= '0;
		end
		// squaring pass: shift the axes through the multiplier
		if (state_q == F_SQUARE) begin
			ax_q  <= ay_q;
			ay_q  <= az_q;
			sum_q <= sum_d;
			if (axis_cnt_q == AXIS_LAST) begin
				rem_q <= sum_d;
				res_q <= '0;
				bit_q <= ROOT_BIT0;
			end
		end
		// restoring square root, one result bit per cycle
		if (state_q == F_ROOT) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == F_SCALE) begin
			mg_q <= prod[LSB_SHIFT +: MAG_W];
		end
	end

	// assertions
	a_root_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_ROOT |-> $onehot(bit_q))
		else $error("square root trial bit is not one-hot");

	a_mg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_PUSH |-> mg_q <= MG_MAX)
		else $error("scaled magnitude above full-scale value");

	a_push_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == F_PUSH) |-> $past(state_q) == F_SCALE)
		else $error("magnitude pushed without scaling");

endmodule : amsd_front
`default_nettype wire

// ----- sv/amsd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amsd_queue
// Two-entry queue of scaled magnitudes between the front and back ends.
// ----------------------------------------------------------------------------
module amsd_queue import amsd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [MAG_W-1:0] push_data,
	input  wire logic             pop,
	output logic      [MAG_W-1:0] pop_data,
	output mq_status_t            stat
);

	logic [MAG_W-1:0] data_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = count_q == 2'd2;
	assign stat.empty = count_q == 2'd0;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = data_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue fill level out of range");

	a_ptr_level: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd1 |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers disagree with fill level");

	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill level");

endmodule : amsd_queue
`default_nettype wire

// ----- sv/amsd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// amsd_back
// Writes each magnitude into the ring window, scans the window once it has
// filled for its minimum and maximum, and holds the stillness flag in an
// output register until it is popped.
// ----------------------------------------------------------------------------
module amsd_back import amsd_pkg::*; #(
	parameter int WINDOW_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mq_status_t       mq_stat,
	input  wire logic [MAG_W-1:0] mq_data,
	output logic                  mq_pop,
	input  wire logic [MAG_W-1:0] thresh,
	output logic                  empty,
	input  wire logic             pop,
	output logic                  is_still
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);

	back_state_t state_q, state_d;

	logic [AW-1:0]    slot_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    fill_d;
	logic [AW-1:0]    scan_idx_q;
	logic             rd_vld_s1;
	logic             rd_first_s1;
	logic [MAG_W-1:0] rd_data;
	logic [MAG_W-1:0] lo_q;
	logic [MAG_W-1:0] hi_q;
	logic             out_vld_q;
	logic             out_still_q;
	logic             ram_rd_en;
	logic             win_full;
	logic             still;
	logic             load_out;

	// window fill level after this write
	assign fill_d   = (fill_q == FULL_CNT) ? fill_q : fill_q + CW'(1);
	assign win_full = fill_q == FULL_CNT;
	assign still    = win_full && ((hi_q - lo_q) <= thresh);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (!mq_stat.empty) state_d = (fill_d == FULL_CNT) ? B_SCAN : B_EMIT;
			B_SCAN:  if (scan_idx_q == LAST_SLOT) state_d = B_DRAIN;
			B_DRAIN: state_d = B_EMIT;
			B_EMIT:  if (!out_vld_q) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mq_pop    = 1'b0;
		ram_rd_en = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			B_IDLE:  mq_pop = !mq_stat.empty;
			B_SCAN:  ram_rd_en = 1'b1;
			B_EMIT:  load_out = !out_vld_q;
			default: ;
		endcase
	end

	// magnitude window
	amsd_ram #(
		.WIDTH (MAG_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.wr_en   (mq_pop),
		.wr_addr (slot_q),
		.wr_data (mq_data),
		.rd_en   (ram_rd_en),
		.rd_addr (scan_idx_q),
		.rd_data (rd_data)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_vld_s1   <= ram_rd_en;
			rd_first_s1 <= scan_idx_q == '0;
			if (mq_pop) begin
				slot_q     <= (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
				fill_q     <= fill_d;
				scan_idx_q <= '0;
			end else if (ram_rd_en) begin
				scan_idx_q <= (scan_idx_q == LAST_SLOT) ? '0 : scan_idx_q + AW'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// running minimum and maximum over the scan
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_first_s1 || rd_data < lo_q) lo_q <= rd_data;
			if (rd_first_s1 || rd_data > hi_q) hi_q <= rd_data;
		end
		if (load_out) begin
			out_still_q <= still;
		end
	end

	assign empty    = !out_vld_q;
	assign is_still = out_still_q;

	// assertions
	a_still_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_still_q |-> win_full)
		else $error("stillness reported before window filled");

	a_scan_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SCAN |-> win_full)
		else $error("window scanned before it filled");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above window depth");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_EMIT && win_full |-> lo_q <= hi_q)
		else $error("window minimum above maximum");

endmodule : amsd_back
`default_nettype wire

// ----- sv/accel_magnitude_stillness_detector_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// accel_magnitude_stillness_detector_core
// Stillness detector on the range of recent accelerometer magnitudes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive accel_x/y/z and raise push while full is low; the
//   sample is taken on that edge. Result queue side: while empty is low,
//   is_still holds the oldest flag; raise pop to take it.
//   Configuration: cfg_data is the stillness threshold in milli-g, written
//   when cfg_valid is high (cfg_ready is always high). Write only while idle.
// Timing:
//   Front end: an accept step, squaring of the three axes on one shared
//   multiplier, a square root resolving one result bit per step, and scale
//   and push steps; a new sample is taken only once the last is pushed.
//   Back end: a window write, then once the window is full a scan of
//   every window slot over the window RAM read port, a drain and an emit.
//   When pop keeps up, the rate is set by the slower of the square root
//   loop and the window scan.
//   Reset clears the window fill count and sets the threshold to 50 mg.
//   If pop stays low, one result waits in the output register, one more
//   waits in the back end, two magnitudes wait in the inner queue and one
//   in the front end, and then full stays high.
// ----------------------------------------------------------------------------
module accel_magnitude_stillness_detector_core import amsd_pkg::*; #(
	parameter int WINDOW_DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [AXIS_W-1:0] accel_x,
	input  wire logic signed [AXIS_W-1:0] accel_y,
	input  wire logic signed [AXIS_W-1:0] accel_z,
	output logic                          empty,
	input  wire logic                     pop,
	output logic                          is_still,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [MAG_W-1:0]         cfg_data
);

	mq_status_t       mq_stat;
	logic             mq_push;
	logic [MAG_W-1:0] mq_push_data;
	logic             mq_pop;
	logic [MAG_W-1:0] mq_pop_data;
	logic [MAG_W-1:0] thresh_q;

	// threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// magnitude front end
	amsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.accel_x (accel_x),
		.accel_y (accel_y),
		.accel_z (accel_z),
		.mq_stat (mq_stat),
		.mq_push (mq_push),
		.mq_data (mq_push_data)
	);

	// queue between front and back
	amsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mq_push),
		.push_data (mq_push_data),
		.pop       (mq_pop),
		.pop_data  (mq_pop_data),
		.stat      (mq_stat)
	);

	// window back end
	amsd_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mq_stat  (mq_stat),
		.mq_data  (mq_pop_data),
		.mq_pop   (mq_pop),
		.thresh   (thresh_q),
		.empty    (empty),
		.pop      (pop),
		.is_still (is_still)
	);

endmodule : accel_magnitude_stillness_detector_core
`default_nettype wire

// ----- test/tb_accel_magnitude_stillness_detector_core.sv -----
// ----------------------------------------------------------------------------
// tb_accel_magnitude_stillness_detector_core
// Self-checking bench for the stillness detector. Samples go in through the
// input queue side and flags come back through the result queue side. Both
// sides idle at random. A predictor in the bench keeps its own magnitude
// window, fill count and threshold, and works out the flag for every
// accepted sample. Each flag taken from the block is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_accel_magnitude_stillness_detector_core;
	import amsd_pkg::*;

	localparam int WINDOW       = 16;
	localparam int RANDOM_ITEMS = 1200;
	localparam int SETTLE       = 64;
	localparam int CYCLE_LIMIT  = 1000000;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     push      = 1'b0;
	logic                     full;
	logic signed [AXIS_W-1:0] accel_x   = '0;
	logic signed [AXIS_W-1:0] accel_y   = '0;
	logic signed [AXIS_W-1:0] accel_z   = '0;
	logic                     empty;
	logic                     pop       = 1'b0;
	logic                     is_still;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [MAG_W-1:0]         cfg_data  = '0;

	// predictor state
	logic [MAG_W-1:0] mag_window [WINDOW];
	logic [3:0]       wr_slot;
	int               fill_cnt;
	logic [MAG_W-1:0] threshold_mg;
	logic             expected_still [$];

	// run bookkeeping
	bit idle_on      = 1'b1;
	int mismatches   = 0;
	int samples_sent = 0;
	int flags_seen   = 0;
	int still_seen   = 0;
	int thr_writes   = 0;
	int cycles       = 0;
	int pop_hold     = 0;

	accel_magnitude_stillness_detector_core #(
		.WINDOW_DEPTH(WINDOW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.empty    (empty),
		.pop      (pop),
		.is_still (is_still),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d flags outstanding", cycles,
				expected_still.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// gap length: mostly none, sometimes a few cycles, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [AXIS_W-1:0] clamp_axis(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return AXIS_W'(v);
	endfunction

	// floor root of the sum of squares, scaled to milli-g
	function automatic logic [MAG_W-1:0] accel_magnitude_mg(
		input logic signed [AXIS_W-1:0] ax,
		input logic signed [AXIS_W-1:0] ay,
		input logic signed [AXIS_W-1:0] az
	);
		longint          sx, sy, sz;
		longint unsigned energy, root, trial, scaled;
		sx = ax;
		sy = ay;
		sz = az;
		energy = longint'(sx * sx + sy * sy + sz * sz);
		root = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= energy)
				root = trial;
		end
		scaled = (root * 1000) >> 14;
		return MAG_W'(scaled);
	endfunction

	// window update and range test for one accepted sample
	function automatic void predict_stillness(
		input logic signed [AXIS_W-1:0] ax,
		input logic signed [AXIS_W-1:0] ay,
		input logic signed [AXIS_W-1:0] az
	);
		logic [MAG_W-1:0] lo, hi;
		mag_window[wr_slot] = accel_magnitude_mg(ax, ay, az);
		wr_slot = wr_slot + 4'd1;
		if (fill_cnt < WINDOW)
			fill_cnt++;
		if (fill_cnt < WINDOW) begin
			expected_still.push_back(1'b0);
			return;
		end
		lo = mag_window[0];
		hi = mag_window[0];
		for (int i = 1; i < WINDOW; i++) begin
			if (mag_window[i] < lo)
				lo = mag_window[i];
			if (mag_window[i] > hi)
				hi = mag_window[i];
		end
		expected_still.push_back((hi - lo) <= threshold_mg);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	// result side: random pop stalls
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold--;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			pop_hold = pick_gap();
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// result side: check every beat taken from the block
	always @(posedge clk) begin
		logic want;
		if (arst_n && pop && !empty) begin
			if (expected_still.size() == 0) begin
				report_mismatch($sformatf("flag %b with nothing expected", is_still));
			end else begin
				want = expected_still.pop_front();
				flags_seen++;
				if (is_still)
					still_seen++;
				if (is_still !== want)
					report_mismatch($sformatf("flag %0d: is_still %b, expected %b",
						flags_seen, is_still, want));
			end
		end
	end

	// one input beat; push stays high when the next sample follows at once
	task automatic send_sample(
		input logic signed [AXIS_W-1:0] ax,
		input logic signed [AXIS_W-1:0] ay,
		input logic signed [AXIS_W-1:0] az
	);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_stillness(ax, ay, az);
		samples_sent++;
	endtask

	// drop push right after the last accepted beat of a burst
	task automatic end_burst();
		push <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_still.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// threshold write, only once the block has gone idle
	task automatic write_threshold(input logic [MAG_W-1:0] thr);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= thr;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		threshold_mg = thr;
		thr_writes++;
		cfg_valid <= 1'b0;
	endtask

	// extremes, fill from reset and the reset threshold
	task automatic test_fill_from_reset();
		send_sample('0, '0, '0);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(16'sh8000, '0, '0);
		send_sample('0, 16'sh7fff, '0);
		send_sample('0, '0, 16'sh8000);
		send_sample(16'sh0001, -16'sh0001, 16'sh0001);
		send_sample(16'sh5555, 16'shaaaa, 16'sh7fff);
		// window fills during these, then holds only 1 g
		repeat (16)
			send_sample('0, '0, 16'sh4000);
		end_burst();
	endtask

	// range exactly at a zero threshold, then the widest threshold
	task automatic test_threshold_edges();
		write_threshold('0);
		send_sample(16'sh4000, '0, '0);
		send_sample('0, -16'sh4000, '0);
		send_sample('0, '0, 16'sh4010);
		end_burst();
		write_threshold('1);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000);
		send_sample('0, '0, '0);
		end_burst();
	endtask

	// segments of near-constant samples with noise, plus motion bursts
	task automatic test_random_traffic();
		int          phase, start, seg_len, amp, r;
		int          bx, by, bz;
		logic [MAG_W-1:0] thr;
		phase = 0;
		start = samples_sent;
		while (samples_sent - start < RANDOM_ITEMS) begin
			case (phase % 6)
				0: thr = '0;
				1: thr = '1;
				2: thr = THRESH_RESET;
				3: thr = MAG_W'($urandom_range(0, 4095));
				default: thr = MAG_W'($urandom_range(0, 150));
			endcase
			write_threshold(thr);
			idle_on = ($urandom_range(0, 4) != 0);
			repeat (6) begin
				r = $urandom_range(0, 99);
				seg_len = $urandom_range(8, 50);
				if (r < 70) begin
					bx = int'($urandom_range(0, 40000)) - 20000;
					by = int'($urandom_range(0, 40000)) - 20000;
					bz = int'($urandom_range(0, 40000)) - 20000;
					case ($urandom_range(0, 4))
						0: amp = 0;
						1: amp = 8;
						2: amp = 300;
						3: amp = 1200;
						default: amp = 4000;
					endcase
					repeat (seg_len) begin
						if ($urandom_range(0, 49) == 0)
							send_sample(AXIS_W'($urandom), AXIS_W'($urandom),
								AXIS_W'($urandom));
						else
							send_sample(
								clamp_axis(bx + int'($urandom_range(0, 2 * amp)) - amp),
								clamp_axis(by + int'($urandom_range(0, 2 * amp)) - amp),
								clamp_axis(bz + int'($urandom_range(0, 2 * amp)) - amp));
					end
				end else begin
					repeat (seg_len)
						send_sample(AXIS_W'($urandom), AXIS_W'($urandom),
							AXIS_W'($urandom));
				end
			end
			end_burst();
			phase++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		threshold_mg = THRESH_RESET;
		wr_slot      = '0;
		fill_cnt     = 0;
		foreach (mag_window[i])
			mag_window[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_from_reset();
		test_threshold_edges();
		test_random_traffic();

		wait_drained();
		$display("%0d samples sent, %0d flags checked, %0d of them still",
			samples_sent, flags_seen, still_seen);
		$display("%0d threshold writes, %0d mismatches", thr_writes, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
